@@ hw/rtl/mini_sha256_tail_round_difference_macros.svh @@
// Assertion macros used by the checker of the tail round difference block
`ifndef MINI_SHA256_TAIL_ROUND_DIFFERENCE_MACROS_SVH
`define MINI_SHA256_TAIL_ROUND_DIFFERENCE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define MSRD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MSRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/msrd_pkg.sv @@
// Package: types, round constants and mixing functions of the byte-wide tail rounds
package msrd_pkg;

	localparam int unsigned WordWidth   = 8;
	localparam int unsigned NumRegs     = 8;
	localparam int unsigned NumRounds   = 7;
	localparam int unsigned NumSched    = 7;
	localparam int unsigned FreeWords   = 4;
	localparam int unsigned NumMsgs     = 2;
	localparam int unsigned SchedFirst  = 3;
	localparam int unsigned SchedLast   = 5;
	localparam int unsigned CfgWidth    = 64;
	localparam int unsigned CfgIdxWidth = 3;
	localparam int unsigned DataWidth   = WordWidth * NumRegs;

	typedef logic [WordWidth-1:0] word_t;
	typedef word_t [NumRegs-1:0] regs_t;
	typedef word_t [NumSched-1:0] sched_t;

	typedef struct packed {
		regs_t  [NumMsgs-1:0] r;
		sched_t [NumMsgs-1:0] w;
	} pipe_t;

	localparam logic [CfgIdxWidth-1:0] CfgStateFirst  = 3'd0;
	localparam logic [CfgIdxWidth-1:0] CfgStateSecond = 3'd1;
	localparam logic [CfgIdxWidth-1:0] CfgSchedFirst  = 3'd2;
	localparam logic [CfgIdxWidth-1:0] CfgSchedSecond = 3'd3;

	localparam word_t RoundK [NumRounds] = '{
		8'h6f, 8'h14, 8'h08, 8'hfa, 8'heb, 8'hf7, 8'hf2
	};

	function automatic word_t rotr(word_t x, int unsigned k);
		logic [2*WordWidth-1:0] d;
		d = {x, x} >> k;
		return d[WordWidth-1:0];
	endfunction

	function automatic word_t big0(word_t x);
		return rotr(x, 1) ^ rotr(x, 3) ^ rotr(x, 6);
	endfunction

	function automatic word_t big1(word_t x);
		return rotr(x, 2) ^ rotr(x, 3) ^ rotr(x, 6);
	endfunction

	function automatic word_t small0(word_t x);
		return rotr(x, 2) ^ rotr(x, 4) ^ (x >> 1);
	endfunction

	function automatic word_t small1(word_t x);
		return rotr(x, 4) ^ rotr(x, 5) ^ (x >> 2);
	endfunction

endpackage

@@ hw/rtl/msrd_stream_if.sv @@
// Valid/ready stream interfaces for the input and result channels
interface msrd_in_if import msrd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DataWidth-1:0] free_bits;

	modport source (output valid, output free_bits, input ready);
	modport sink (input valid, input free_bits, output ready);
endinterface

interface msrd_out_if import msrd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DataWidth-1:0] state_difference;

	modport source (output valid, output state_difference, input ready);
	modport sink (input valid, input state_difference, output ready);
endinterface

@@ hw/rtl/msrd_round_cell.sv @@
// One round of both messages, with optional schedule extension, as a pipeline cell
module msrd_round_cell import msrd_pkg::*; #(
	parameter int unsigned ROUND = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sched_t [NumMsgs-1:0] sched,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pipe_t                in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pipe_t                out_data
);

	logic  valid_q;
	pipe_t data_q;
	pipe_t next;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		word_t ch, mj, t1, t2;
		next = in_data;
		for (int m = 0; m < NumMsgs; m++) begin
			ch = (in_data.r[m][4] & in_data.r[m][5]) ^ (~in_data.r[m][4] & in_data.r[m][6]);
			mj = (in_data.r[m][0] & in_data.r[m][1]) ^ (in_data.r[m][0] & in_data.r[m][2])
				^ (in_data.r[m][1] & in_data.r[m][2]);
			t1 = in_data.r[m][7] + big1(in_data.r[m][4]) + ch + RoundK[ROUND]
				+ in_data.w[m][ROUND];
			t2 = big0(in_data.r[m][0]) + mj;
			next.r[m][7] = in_data.r[m][6];
			next.r[m][6] = in_data.r[m][5];
			next.r[m][5] = in_data.r[m][4];
			next.r[m][4] = in_data.r[m][3] + t1;
			next.r[m][3] = in_data.r[m][2];
			next.r[m][2] = in_data.r[m][1];
			next.r[m][1] = in_data.r[m][0];
			next.r[m][0] = t1 + t2;
		end
	end

	pipe_t ext;

	if (ROUND >= SchedFirst && ROUND <= SchedLast) begin : g_sched
		localparam int unsigned J = ROUND - SchedFirst;
		always_comb begin
			ext = next;
			for (int m = 0; m < NumMsgs; m++) begin
				ext.w[m][ROUND+1] = small1(in_data.w[m][ROUND-1]) + sched[m][4+J]
					+ small0(sched[m][1+J]) + sched[m][J];
			end
		end
	end else begin : g_nosched
		assign ext = next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= ext;
		end
	end

endmodule

@@ hw/rtl/mini_sha256_tail_round_difference.sv @@
// Top level: configuration registers and the chain of seven round cells
//
// Usage:
//   Input channel in_ch carries free_bits: bytes 0..3 are schedule words
//   57..60 of the first message, bytes 4..7 those of the second message.
//   Result channel out_ch carries state_difference, the byte-wise XOR of
//   the final registers a..h of both messages (byte i is register i).
//   Configuration: cfg_we, cfg_index, cfg_data. Index 0/1 write the working
//   registers after round 56 of message one/two, index 2/3 write the fixed
//   schedule words 45,46,47,48,54,55,56 (bits above 55 dropped). Other
//   indexes are ignored. Write only while no beat is in flight.
//   An accepted input beat passes through the seven round cells, one round
//   per cell, to the result beat; a new beat is taken every cycle unless the
//   receiver stalls. Throughput: one item per cycle while not stalled,
//   set by the seven-cell round chain; the last cell is the output register.
//   Reset clears all cell valid bits and all configuration registers to 0.
//   When the receiver stalls, cells fill up from the output backward and
//   in_ch.ready drops once every cell holds a beat.
module mini_sha256_tail_round_difference import msrd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_data,
	msrd_in_if.sink                in_ch,
	msrd_out_if.source             out_ch
);

	regs_t  [NumMsgs-1:0] state_q;
	sched_t [NumMsgs-1:0] sched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			sched_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgStateFirst:  state_q[0] <= cfg_data;
				CfgStateSecond: state_q[1] <= cfg_data;
				CfgSchedFirst:  sched_q[0] <= cfg_data[WordWidth*NumSched-1:0];
				CfgSchedSecond: sched_q[1] <= cfg_data[WordWidth*NumSched-1:0];
				default: ;
			endcase
		end
	end

	logic  link_valid [NumRounds+1];
	logic  link_ready [NumRounds+1];
	pipe_t link_data  [NumRounds+1];
	pipe_t head;

	always_comb begin
		head = '0;
		for (int m = 0; m < NumMsgs; m++) begin
			head.r[m] = state_q[m];
			for (int k = 0; k < FreeWords; k++) begin
				head.w[m][k] = in_ch.free_bits[(m*FreeWords+k)*WordWidth +: WordWidth];
			end
		end
	end

	assign link_data[0]  = head;
	assign link_valid[0] = in_ch.valid;
	assign in_ch.ready   = link_ready[0];

	for (genvar i = 0; i < NumRounds; i++) begin : g_cell
		msrd_round_cell #(
			.ROUND(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.sched    (sched_q),
			.in_valid (link_valid[i]),
			.in_ready (link_ready[i]),
			.in_data  (link_data[i]),
			.out_valid(link_valid[i+1]),
			.out_ready(link_ready[i+1]),
			.out_data (link_data[i+1])
		);
	end

	assign link_ready[NumRounds] = out_ch.ready;
	assign out_ch.valid          = link_valid[NumRounds];
	assign out_ch.state_difference = link_data[NumRounds].r[0] ^ link_data[NumRounds].r[1];

endmodule

@@ hw/rtl/msrd_checker.sv @@
// Port-level checker for the tail round difference block, with its bind
`include "mini_sha256_tail_round_difference_macros.svh"

module msrd_checker import msrd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DataWidth-1:0] out_data
);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	`MSRD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed or dropped")
	`MSRD_ASSERT(a_ready_through, clk, arst_n, out_ready |-> in_ready, "input stalled while the receiver takes results")
	`MSRD_ASSERT(a_latency, clk, arst_n, in_fire && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "result beat missing seven cycles after input")
	`MSRD_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind mini_sha256_tail_round_difference msrd_checker u_msrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.state_difference)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the tail round difference block: predicts and compares every beat
module tb_top;
	import msrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TailLatency = 7;
	localparam logic [CfgIdxWidth-1:0] CfgFirstUnused = 3'd4;
	localparam logic [CfgIdxWidth-1:0] CfgLastIndex = '1;
	localparam word_t TailK [NumRounds] = '{
		8'h6f, 8'h14, 8'h08, 8'hfa, 8'heb, 8'hf7, 8'hf2
	};

	typedef struct {
		logic [DataWidth-1:0] free_bits;
		logic [DataWidth-1:0] diff;
	} diff_exp_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CfgIdxWidth-1:0] cfg_index;
	logic [CfgWidth-1:0]    cfg_data;

	msrd_in_if  in_if ();
	msrd_out_if out_if ();

	mini_sha256_tail_round_difference dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// predictor copy of the configuration
	logic [63:0] cur_state_first;
	logic [63:0] cur_state_second;
	logic [55:0] cur_sched_first;
	logic [55:0] cur_sched_second;

	diff_exp_t diff_q[$];
	int unsigned mismatches;
	int unsigned beats_sent;
	int unsigned beats_checked;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        hold_on;

	function automatic word_t ror8(word_t x, int unsigned k);
		return (x >> k) | (x << (WordWidth - k));
	endfunction

	function automatic word_t sum0(word_t x);
		return ror8(x, 1) ^ ror8(x, 3) ^ ror8(x, 6);
	endfunction

	function automatic word_t sum1(word_t x);
		return ror8(x, 2) ^ ror8(x, 3) ^ ror8(x, 6);
	endfunction

	function automatic word_t sig0(word_t x);
		return ror8(x, 2) ^ ror8(x, 4) ^ (x >> 1);
	endfunction

	function automatic word_t sig1(word_t x);
		return ror8(x, 4) ^ ror8(x, 5) ^ (x >> 2);
	endfunction

	// final a..h of one message after rounds 57..63
	function automatic logic [63:0] tail_regs(logic [63:0] st, logic [55:0] sc,
			logic [31:0] words);
		word_t w [NumRounds];
		word_t r [NumRegs];
		word_t ch, mj, t1, t2;
		logic [63:0] packed_regs;
		for (int i = 0; i < FreeWords; i++) w[i] = words[8*i +: 8];
		w[4] = sig1(w[2]) + sc[32 +: 8] + sig0(sc[8 +: 8]) + sc[0 +: 8];
		w[5] = sig1(w[3]) + sc[40 +: 8] + sig0(sc[16 +: 8]) + sc[8 +: 8];
		w[6] = sig1(w[4]) + sc[48 +: 8] + sig0(sc[24 +: 8]) + sc[16 +: 8];
		for (int i = 0; i < NumRegs; i++) r[i] = st[8*i +: 8];
		for (int i = 0; i < NumRounds; i++) begin
			ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
			mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
			t1 = r[7] + sum1(r[4]) + ch + TailK[i] + w[i];
			t2 = sum0(r[0]) + mj;
			r[7] = r[6];
			r[6] = r[5];
			r[5] = r[4];
			r[4] = r[3] + t1;
			r[3] = r[2];
			r[2] = r[1];
			r[1] = r[0];
			r[0] = t1 + t2;
		end
		packed_regs = '0;
		for (int i = 0; i < NumRegs; i++) packed_regs[8*i +: 8] = r[i];
		return packed_regs;
	endfunction

	function automatic logic [63:0] predict_difference(logic [63:0] fb);
		return tail_regs(cur_state_first, cur_sched_first, fb[31:0])
			^ tail_regs(cur_state_second, cur_sched_second, fb[63:32]);
	endfunction

	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return {8'h00, $urandom, 24'($urandom)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic word_t pick_byte();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h01;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_free_bits();
		logic [63:0] v;
		if ($urandom_range(9) == 0) begin
			for (int i = 0; i < NumRegs; i++) v[8*i +: 8] = pick_byte();
		end else begin
			v = {$urandom, $urandom};
		end
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] fb, logic [63:0] exp_v,
			logic [63:0] got_v);
		$display("ERROR: %s (free_bits %h): expected %h, got %h", what, fb, exp_v, got_v);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Timeout: run did not finish");
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// predict on each accepted input beat, check each accepted result beat
	always @(posedge clk) begin
		diff_exp_t e;
		if (in_if.valid && in_if.ready) begin
			e.free_bits = in_if.free_bits;
			e.diff = predict_difference(in_if.free_bits);
			diff_q.push_back(e);
		end
		if (out_if.valid && out_if.ready) begin
			beats_checked++;
			if (diff_q.size() == 0) begin
				report_mismatch("unexpected result beat", '0, '0, out_if.state_difference);
			end else begin
				e = diff_q.pop_front();
				if (out_if.state_difference !== e.diff)
					report_mismatch("state_difference", e.free_bits, e.diff,
						out_if.state_difference);
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_free_bits(logic [63:0] fb);
		int unsigned gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
		repeat (gap) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.free_bits <= fb;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		@(negedge clk);
		while (diff_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CfgStateFirst:  cur_state_first = data;
			CfgStateSecond: cur_state_second = data;
			CfgSchedFirst:  cur_sched_first = data[55:0];
			CfgSchedSecond: cur_sched_second = data[55:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_regs(logic [63:0] sf, logic [63:0] ss, logic [63:0] cf,
			logic [63:0] cs);
		write_reg(CfgStateFirst, sf);
		write_reg(CfgStateSecond, ss);
		write_reg(CfgSchedFirst, cf);
		write_reg(CfgSchedSecond, cs);
	endtask

	task automatic send_extremes();
		send_free_bits('0);
		send_free_bits('1);
		send_free_bits(64'h0000_0000_ffff_ffff);
		send_free_bits(64'hffff_ffff_0000_0000);
		send_free_bits(64'h8080_8080_8080_8080);
		send_free_bits(64'h0101_0101_0101_0101);
	endtask

	task automatic test_reset_values();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_free_bits('0);
		send_free_bits('1);
		wait_drained();
	endtask

	task automatic test_extreme_config();
		program_regs('1, '1, '1, '1);
		send_extremes();
		wait_drained();
		program_regs('1, '0, 64'h00ff_ffff_ffff_ffff, '0);
		send_free_bits(64'h5555_5555_aaaa_aaaa);
		send_free_bits(64'haaaa_aaaa_5555_5555);
		wait_drained();
	endtask

	// bits above 55 of the schedule registers must have no effect
	task automatic test_sched_upper_bits();
		program_regs(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			64'hff00_0000_0000_0000, 64'ha500_0000_0000_0000);
		send_free_bits(64'h1234_5678_9abc_def0);
		send_free_bits('1);
		wait_drained();
	endtask

	// writes to indexes past the last register must change nothing
	task automatic test_unused_index();
		for (int i = CfgFirstUnused; i <= CfgLastIndex; i++)
			write_reg(CfgIdxWidth'(i), '1);
		send_free_bits(64'h1234_5678_9abc_def0);
		send_free_bits('0);
		wait_drained();
	endtask

	task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct,
			int unsigned n_items);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int c = 0; c < 2; c++) begin
			wait_drained();
			program_regs(pick_reg_value(), pick_reg_value(),
				{$urandom, $urandom}, pick_reg_value());
			repeat (n_items) send_free_bits(rand_free_bits());
		end
		wait_drained();
	endtask

	// receiver held off while the sender keeps offering: the chain fills and stalls in_ch
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_regs({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		fork
			begin
				@(posedge clk);
				hold_on = 1'b1;
				repeat (300) @(posedge clk);
				hold_on = 1'b0;
			end
		join_none
		repeat (60) send_free_bits(rand_free_bits());
		wait_drained();
	endtask

	initial begin
		mismatches = 0;
		beats_sent = 0;
		beats_checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_on = 1'b0;
		cur_state_first = '0;
		cur_state_second = '0;
		cur_sched_first = '0;
		cur_sched_second = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.free_bits = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_extreme_config();
		test_sched_upper_bits();
		test_unused_index();
		test_random_traffic(0, 0, 150);
		test_random_traffic(57, 0, 150);
		test_random_traffic(0, 57, 150);
		test_random_traffic(17, 17, 150);
		test_backpressure();

		repeat (2 * TailLatency) @(negedge clk);
		$display("Covered reset values, extreme and random register settings, ignored index");
		$display("and schedule bits, idle/stall mixes and a long hold-off: %0d beats in, %0d out",
			beats_sent, beats_checked);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/msrd_pkg.sv
hw/rtl/msrd_stream_if.sv
hw/rtl/msrd_round_cell.sv
hw/rtl/mini_sha256_tail_round_difference.sv
hw/rtl/msrd_checker.sv
tb/tb_top.sv
